/* hw/rtl/gtsdf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtsdf_pkg
// shared types and constants for the socket message deframer
// ----------------------------------------------------------------------------
package gtsdf_pkg;

  localparam int unsigned LEN_W = 27;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 27'd1000000;
  localparam logic [LEN_W-1:0] MIN_LEN = 27'd2;

  localparam logic [7:0] SOH_CHAR  = 8'h01;
  localparam logic [7:0] ETX_CHAR  = 8'h03;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_N    = 8'h4E;
  localparam logic [7:0] CHAR_B    = 8'h42;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_F    = 8'h46;
  localparam logic [7:0] CHAR_X    = 8'h58;

  typedef enum logic [1:0] {
    KIND_AN = 2'd0,
    KIND_BI = 2'd1,
    KIND_FX = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_TYPE    = 3'd1,
    ST_NONNUMERIC  = 3'd2,
    ST_BAD_LENGTH  = 3'd3,
    ST_NO_SOH      = 3'd4,
    ST_NO_ETX      = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       first;
    logic       last;
    status_t    status;
  } result_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_flags_t;

endpackage
`default_nettype wire

/* hw/rtl/gts_socket_message_deframer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gts_socket_message_deframer_core
// splits a socket byte stream into length-framed messages
// ----------------------------------------------------------------------------
// throughput: one input byte per cycle, sustained, while the output side
//   keeps up; the result queue absorbs short output stalls
// result path: the parser writes each result into the queue at the input
//   edge, and the output register loads it from the queue head
// reset: synchronous, clears parser state, queue and output valid, and
//   loads the maximum length register with 1000000; no clearing pass
// ----------------------------------------------------------------------------
module gts_socket_message_deframer_core import gtsdf_pkg::*; #(
  parameter int unsigned LENGTH_DIGITS = 8,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // maximum length register
  input  wire logic             cfg_write,
  input  wire logic [LEN_W-1:0] cfg_data,
  // byte stream in
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire logic [7:0]       in_byte,
  // body bytes and status out
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [7:0]       out_byte,
  output      logic [1:0]       message_kind,
  output      logic             first_of_message,
  output      logic             last_of_message,
  output      logic [2:0]       status
);

  logic         in_xfer;
  logic         q_push;
  result_t      q_push_data;
  logic         q_pop;
  result_t      q_head;
  queue_flags_t q_flags;
  result_t      out_res;

  // at most one result per byte, so a free slot is all the parser needs
  assign in_stall = q_flags.full;
  assign in_xfer  = in_valid && !in_stall;

  gtsdf_front #(
    .LENGTH_DIGITS(LENGTH_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (in_xfer),
    .in_byte   (in_byte),
    .push      (q_push),
    .push_data (q_push_data)
  );

  gtsdf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .flags     (q_flags)
  );

  // output register decouples the queue from the downstream stall
  gtsdf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .flags     (q_flags),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte         = out_res.data;
  assign message_kind     = out_res.kind;
  assign first_of_message = out_res.first;
  assign last_of_message  = out_res.last;
  assign status           = out_res.status;

`ifndef SYNTHESIS
  a_first_is_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && first_of_message |-> !last_of_message && status == ST_OK)
    else $error("opening byte flagged as last or error");
`endif

endmodule
`default_nettype wire

/* hw/rtl/gtsdf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtsdf_front
// header parser and body classifier, one byte per transfer
// ----------------------------------------------------------------------------
module gtsdf_front import gtsdf_pkg::*; #(
  parameter int unsigned LENGTH_DIGITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [LEN_W-1:0] cfg_data,
  input  wire logic             accept,
  input  wire logic [7:0]       in_byte,
  output      logic             push,
  output      result_t          push_data
);

  localparam int unsigned HPW = $clog2(LENGTH_DIGITS + 3);
  localparam logic [HPW-1:0] POS_TYPE0 = HPW'(LENGTH_DIGITS);
  localparam logic [HPW-1:0] POS_TYPE1 = HPW'(LENGTH_DIGITS + 1);
  localparam logic [HPW-1:0] POS_BODY  = HPW'(LENGTH_DIGITS + 2);

  logic [LEN_W-1:0] max_len;
  logic [HPW-1:0]   hdr_pos, hdr_pos_next;
  logic [LEN_W-1:0] length_value, length_value_next;
  logic             digit_fault, digit_fault_next;
  logic [7:0]       type_first, type_first_next;
  kind_t            current_kind, current_kind_next;
  logic [LEN_W-1:0] body_remaining, body_remaining_next;
  logic             halted, halted_next;

  logic             is_digit;
  logic [3:0]       digit_val;
  logic [7:0]       digit_diff;
  logic [LEN_W-1:0] length_acc;
  logic             type_ok;
  kind_t            type_kind;

  assign is_digit   = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
  assign digit_diff = in_byte - CHAR_ZERO;
  assign digit_val  = digit_diff[3:0];
  // times ten as shift and add, wraps at register width
  assign length_acc = (length_value << 3) + (length_value << 1) + LEN_W'(digit_val);

  always_comb begin
    type_ok   = 1'b1;
    type_kind = KIND_AN;
    if (type_first == CHAR_A && in_byte == CHAR_N) begin
      type_kind = KIND_AN;
    end else if (type_first == CHAR_B && in_byte == CHAR_I) begin
      type_kind = KIND_BI;
    end else if (type_first == CHAR_F && in_byte == CHAR_X) begin
      type_kind = KIND_FX;
    end else begin
      type_ok = 1'b0;
    end
  end

  always_comb begin
    hdr_pos_next        = hdr_pos;
    length_value_next   = length_value;
    digit_fault_next    = digit_fault;
    type_first_next     = type_first;
    current_kind_next   = current_kind;
    body_remaining_next = body_remaining;
    halted_next         = halted;
    push                = 1'b0;
    push_data.data      = in_byte;
    push_data.kind      = current_kind;
    push_data.first     = 1'b0;
    push_data.last      = 1'b0;
    push_data.status    = ST_OK;
    if (accept && !halted) begin
      if (hdr_pos < POS_TYPE0) begin
        if (is_digit) begin
          length_value_next = length_acc;
        end else begin
          digit_fault_next = 1'b1;
        end
        hdr_pos_next = hdr_pos + 1'b1;
      end else if (hdr_pos == POS_TYPE0) begin
        type_first_next = in_byte;
        hdr_pos_next    = POS_TYPE1;
      end else if (hdr_pos == POS_TYPE1) begin
        push_data.kind = KIND_AN;
        push_data.last = 1'b1;
        if (!type_ok) begin
          push             = 1'b1;
          halted_next      = 1'b1;
          push_data.status = ST_BAD_TYPE;
        end else if (digit_fault) begin
          push             = 1'b1;
          halted_next      = 1'b1;
          push_data.status = ST_NONNUMERIC;
        end else if (length_value > max_len || length_value < MIN_LEN) begin
          push             = 1'b1;
          halted_next      = 1'b1;
          push_data.status = ST_BAD_LENGTH;
        end else begin
          current_kind_next   = type_kind;
          body_remaining_next = length_value;
          hdr_pos_next        = POS_BODY;
        end
      end else begin
        push = 1'b1;
        if (body_remaining == length_value) begin
          // opening byte of the body
          if (in_byte != SOH_CHAR) begin
            halted_next      = 1'b1;
            push_data.last   = 1'b1;
            push_data.status = ST_NO_SOH;
          end else begin
            body_remaining_next = body_remaining - 1'b1;
            push_data.first     = 1'b1;
          end
        end else if (body_remaining <= LEN_W'(1)) begin
          push_data.last      = 1'b1;
          hdr_pos_next        = '0;
          length_value_next   = '0;
          digit_fault_next    = 1'b0;
          type_first_next     = '0;
          body_remaining_next = '0;
          if (in_byte != ETX_CHAR) begin
            halted_next      = 1'b1;
            push_data.status = ST_NO_ETX;
          end
        end else begin
          body_remaining_next = body_remaining - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len        <= MAX_LEN_RESET;
      hdr_pos        <= '0;
      length_value   <= '0;
      digit_fault    <= 1'b0;
      type_first     <= '0;
      current_kind   <= KIND_AN;
      body_remaining <= '0;
      halted         <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_len <= cfg_data;
      end
      hdr_pos        <= hdr_pos_next;
      length_value   <= length_value_next;
      digit_fault    <= digit_fault_next;
      type_first     <= type_first_next;
      current_kind   <= current_kind_next;
      body_remaining <= body_remaining_next;
      halted         <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_body_bound: assert property (@(posedge clk) disable iff (rst)
    hdr_pos == POS_BODY |-> body_remaining <= length_value)
    else $error("body count above message length");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    halted |-> !push)
    else $error("result produced while halted");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    push && push_data.status != ST_OK |=> halted)
    else $error("error result did not halt the parser");
`endif

endmodule
`default_nettype wire

/* hw/rtl/gtsdf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtsdf_queue
// short result queue between parser and output stage
// ----------------------------------------------------------------------------
module gtsdf_queue import gtsdf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output      result_t head,
  output      queue_flags_t flags
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  result_t       entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head        = entries[rd_ptr];
  assign flags.empty = (count == '0);
  assign flags.full  = (count == FULL_COUNT);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count <= FULL_COUNT) && !(push && flags.full) && !(pop && flags.empty))
    else $error("queue overflow or underflow");
`endif

endmodule
`default_nettype wire

/* hw/rtl/gtsdf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gtsdf_back
// output register, drains the queue one result per transfer
// ----------------------------------------------------------------------------
module gtsdf_back import gtsdf_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire queue_flags_t flags,
  input  wire result_t      head,
  output      logic         pop,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output      result_t      out_res
);

  assign pop = !flags.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (pop) begin
      out_res <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* dv/gts_socket_message_deframer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gts_socket_message_deframer_core_tb
// self-checking bench for the socket message deframer
// framed messages of all three types pass through several maximum-length
// settings with random idle bursts on both sides; the run closes with one
// framing error and a few ignored bytes, since an error halts the block
// until reset
// ----------------------------------------------------------------------------
module gts_socket_message_deframer_core_tb;
  import gtsdf_pkg::*;

  localparam int unsigned HDR_DIGITS = 8;
  localparam int unsigned LONG_HOLD  = 300;  // receiver hold-off, in cycles
  localparam int unsigned SETTLE     = 8;    // cycles past the last result

  // --------------------------------------------------------------------------
  // expected-result tracker: own copy of the parser state plus a queue of
  // results still owed by the block
  // --------------------------------------------------------------------------
  class frame_tracker;
    result_t          owed[$];
    int unsigned      err_count;
    logic [LEN_W-1:0] max_len;
    int unsigned      hdr_pos;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] remaining;
    bit               digit_bad;
    bit               stopped;
    logic [7:0]       type_c0;
    kind_t            cur_kind;

    function new();
      max_len   = MAX_LEN_RESET;
      cur_kind  = KIND_AN;
      stopped   = 1'b0;
      err_count = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_pos   = 0;
      len_acc   = '0;
      remaining = '0;
      digit_bad = 1'b0;
      type_c0   = 8'h00;
    endfunction

    function void owe(logic [7:0] b, kind_t k, logic f, logic l, status_t s);
      result_t r;
      r.data   = b;
      r.kind   = k;
      r.first  = f;
      r.last   = l;
      r.status = s;
      owed.push_back(r);
    endfunction

    // advance the parser by one accepted byte
    function void take_byte(logic [7:0] b);
      kind_t k;
      bit    kind_ok;
      if (stopped) return;
      if (hdr_pos < HDR_DIGITS) begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
          len_acc = LEN_W'(len_acc * 10 + (b - CHAR_ZERO));
        else digit_bad = 1'b1;
        hdr_pos++;
      end else if (hdr_pos == HDR_DIGITS) begin
        type_c0 = b;
        hdr_pos++;
      end else if (hdr_pos == HDR_DIGITS + 1) begin
        kind_ok = 1'b1;
        k = KIND_AN;
        if (type_c0 == CHAR_A && b == CHAR_N) k = KIND_AN;
        else if (type_c0 == CHAR_B && b == CHAR_I) k = KIND_BI;
        else if (type_c0 == CHAR_F && b == CHAR_X) k = KIND_FX;
        else kind_ok = 1'b0;
        // type first, then digits, then range
        if (!kind_ok) begin
          stopped = 1'b1;
          owe(b, KIND_AN, 1'b0, 1'b1, ST_BAD_TYPE);
        end else if (digit_bad) begin
          stopped = 1'b1;
          owe(b, KIND_AN, 1'b0, 1'b1, ST_NONNUMERIC);
        end else if (len_acc > max_len || len_acc < MIN_LEN) begin
          stopped = 1'b1;
          owe(b, KIND_AN, 1'b0, 1'b1, ST_BAD_LENGTH);
        end else begin
          cur_kind  = k;
          remaining = len_acc;
          hdr_pos   = HDR_DIGITS + 2;
        end
      end else if (remaining == len_acc) begin
        if (b != SOH_CHAR) begin
          stopped = 1'b1;
          owe(b, cur_kind, 1'b0, 1'b1, ST_NO_SOH);
        end else begin
          remaining--;
          owe(b, cur_kind, 1'b1, 1'b0, ST_OK);
        end
      end else if (remaining <= 1) begin
        if (b == ETX_CHAR) begin
          owe(b, cur_kind, 1'b0, 1'b1, ST_OK);
        end else begin
          owe(b, cur_kind, 1'b0, 1'b1, ST_NO_ETX);
          stopped = 1'b1;
        end
        clear_frame();
      end else begin
        remaining--;
        owe(b, cur_kind, 1'b0, 1'b0, ST_OK);
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        err_count++;
      end
    endfunction

    // compare one output transfer against the oldest owed result
    function void match_result(logic [7:0] b, logic [1:0] k, logic f, logic l,
                               logic [2:0] s);
      result_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: out_byte %0h status %0d", b, s);
        err_count++;
        return;
      end
      want = owed.pop_front();
      check_field("out_byte", want.data, b);
      check_field("message_kind", want.kind, k);
      check_field("first_of_message", want.first, f);
      check_field("last_of_message", want.last, l);
      check_field("status", want.status, s);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_write = 1'b0;
  logic [LEN_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic [1:0]       message_kind;
  logic             first_of_message;
  logic             last_of_message;
  logic [2:0]       status;

  frame_tracker     tracker;
  bit               quiet = 1'b0;          // no idling on either side
  bit               sender_gaps = 1'b1;    // per-message idle mode of the sender
  bit               long_hold_req = 1'b0;  // ask the receiver for a long hold-off
  int unsigned      bytes_sent = 0;

  gts_socket_message_deframer_core uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .message_kind     (message_kind),
    .first_of_message (first_of_message),
    .last_of_message  (last_of_message),
    .status           (status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard limit on run length
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // output side: every transfer is checked; values read at the edge are the
  // ones from before it
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.match_result(out_byte, message_kind, first_of_message, last_of_message, status);
  end

  // receiver stall pattern: random bursts, calm stretches, one long hold-off
  initial begin : out_stall_gen
    int unsigned n;
    int unsigned r;
    bit          was_long;
    forever begin
      @(posedge clk);
      was_long = 1'b0;
      r = $urandom_range(0, 99);
      if (long_hold_req) begin
        n = LONG_HOLD;
        was_long = 1'b1;
      end else if (!quiet && !rst && r < 12) n = $urandom_range(1, 19);
      else n = 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        if (was_long) long_hold_req = 1'b0;
      end else if (r >= 97) begin
        // calm stretch, receiver always ready
        out_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one byte transfer, with an optional idle burst in front of it
  task automatic send_byte(input logic [7:0] b);
    if (!quiet && !long_hold_req && sender_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    tracker.take_byte(b);
  endtask

  function automatic logic [15:0] type_pair(kind_t k);
    case (k)
      KIND_BI: return {CHAR_B, CHAR_I};
      KIND_FX: return {CHAR_F, CHAR_X};
      default: return {CHAR_A, CHAR_N};
    endcase
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] b;
    if ($urandom_range(0, 3) == 0) return 8'h00;
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  // eight decimal length digits, one optionally spoiled, then the type pair
  task automatic send_header(input int unsigned len, input logic [15:0] tchars,
                             input int bad_pos);
    int unsigned div;
    logic [7:0]  d;
    div = 10000000;
    for (int i = 0; i < HDR_DIGITS; i++) begin
      d = CHAR_ZERO + 8'((len / div) % 10);
      if (i == bad_pos) d = rand_non_digit();
      send_byte(d);
      div = div / 10;
    end
    send_byte(tchars[15:8]);
    send_byte(tchars[7:0]);
  endtask

  // body of len bytes: SOH, random content, ETX, either end optionally wrong
  task automatic send_body(input int unsigned len, input bit soh_ok, input bit etx_ok);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == 0) begin
        b = SOH_CHAR;
        if (!soh_ok) do b = 8'($urandom_range(0, 255)); while (b == SOH_CHAR);
      end else if (i == len - 1) begin
        b = ETX_CHAR;
        if (!etx_ok) do b = 8'($urandom_range(0, 255)); while (b == ETX_CHAR);
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(b);
    end
  endtask

  task automatic send_message(input int unsigned len, input kind_t k);
    sender_gaps = ($urandom_range(0, 3) != 0);
    send_header(len, type_pair(k), -1);
    send_body(len, 1'b1, 1'b1);
  endtask

  // mostly short bodies, some up to 150 bytes, and the cap itself when small
  function automatic int unsigned pick_length(logic [LEN_W-1:0] cap);
    int unsigned hi;
    int unsigned r;
    r  = $urandom_range(0, 99);
    hi = (cap < 150) ? cap : 150;
    if (r < 8) return hi;
    if (r < 14) return $urandom_range(2, hi);
    hi = (cap < 20) ? cap : 20;
    return $urandom_range(2, hi);
  endfunction

  // stop offering and let every owed result come out
  task automatic drain_output();
    in_valid <= 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [LEN_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    tracker.max_len = v;
    cfg_write <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    logic [LEN_W-1:0] caps[6];
    logic [LEN_W-1:0] closing_cap;
    int unsigned      goal;
    int unsigned      len;
    logic [15:0]      tp;
    status_t          flaw;

    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: all three types at the reset cap, extreme body bytes
    send_header(2, type_pair(KIND_AN), -1);
    send_body(2, 1'b1, 1'b1);
    send_header(4, type_pair(KIND_BI), -1);
    send_byte(SOH_CHAR);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ETX_CHAR);
    send_header(2, type_pair(KIND_FX), -1);
    send_body(2, 1'b1, 1'b1);

    // random messages under a series of caps, extremes included
    caps[0] = MIN_LEN;
    caps[1] = LEN_W'($urandom_range(3, 40));
    caps[2] = 27'd99999999;
    caps[3] = {LEN_W{1'b1}};
    caps[4] = MAX_LEN_RESET;
    caps[5] = LEN_W'($urandom_range(2, 99999999));
    foreach (caps[p]) begin
      drain_output();
      write_max_len(caps[p]);
      // the first phase opens with the receiver holding off while bytes
      // keep coming, so the result queue fills and the input stalls
      if (p == 0) long_hold_req = 1'b1;
      goal = bytes_sent + 100;
      while (bytes_sent < goal)
        send_message(pick_length(caps[p]), kind_t'($urandom_range(0, 2)));
    end

    // closing phase, no idling: one good message, then a single framing error
    drain_output();
    quiet = 1'b1;
    closing_cap = LEN_W'($urandom_range(2, 500));
    write_max_len(closing_cap);
    send_message(pick_length(closing_cap), kind_t'($urandom_range(0, 2)));
    flaw = status_t'($urandom_range(ST_BAD_TYPE, ST_NO_ETX));
    case (flaw)
      ST_BAD_TYPE: begin
        // type wins over spoiled digits and an out-of-range length
        do begin
          if ($urandom_range(0, 1)) tp = {8'(type_pair(kind_t'($urandom_range(0, 2))) >> 8),
                                          8'($urandom_range(0, 255))};
          else tp = 16'($urandom_range(0, 65535));
        end while (tp == type_pair(KIND_AN) || tp == type_pair(KIND_BI) ||
                   tp == type_pair(KIND_FX));
        len = $urandom_range(0, 1) ? 0 : pick_length(closing_cap);
        send_header(len, tp, $urandom_range(0, 1) ? int'($urandom_range(0, 7)) : -1);
      end
      ST_NONNUMERIC: begin
        // digits checked before the length range
        len = $urandom_range(0, 1) ? closing_cap + 1 : pick_length(closing_cap);
        send_header(len, type_pair(kind_t'($urandom_range(0, 2))),
                    int'($urandom_range(0, 7)));
      end
      ST_BAD_LENGTH: begin
        case ($urandom_range(0, 3))
          0: len = $urandom_range(0, 1);
          1: len = closing_cap + 1;
          2: len = 99999999;
          default: begin
            // a cap below the minimum rejects every length
            drain_output();
            write_max_len(LEN_W'($urandom_range(0, 1)));
            len = $urandom_range(2, 10);
          end
        endcase
        send_header(len, type_pair(kind_t'($urandom_range(0, 2))), -1);
      end
      ST_NO_SOH: begin
        len = pick_length(closing_cap);
        send_header(len, type_pair(kind_t'($urandom_range(0, 2))), -1);
        send_body(len, 1'b0, 1'b1);
      end
      default: begin
        // body bytes before the bad end still come out
        len = pick_length(closing_cap);
        send_header(len, type_pair(kind_t'($urandom_range(0, 2))), -1);
        send_body(len, 1'b1, 1'b0);
      end
    endcase
    // halted block: these give nothing
    repeat (8) send_byte(8'($urandom_range(0, 255)));

    drain_output();
    if (tracker.err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/gtsdf_pkg.sv
hw/rtl/gtsdf_front.sv
hw/rtl/gtsdf_queue.sv
hw/rtl/gtsdf_back.sv
hw/rtl/gts_socket_message_deframer_core.sv
dv/gts_socket_message_deframer_core_tb.sv
